### rtl/core/bsfs_pkg.sv
// Shared types, constants and helpers for the byte stream field splitter.
// No dependencies; used by every file under rtl/core.
package bsfs_pkg;

  localparam int POS_W       = 15;
  localparam int SEP_BYTES_W = 64;
  localparam int SEP_LEN_W   = 4;
  localparam int CFG_IDX_W   = 2;

  localparam int SEP_MAX_DEF     = 8;
  localparam int MAX_LEN_DEF     = 32767;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [CFG_IDX_W-1:0] REG_SEP_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEP_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WS_MODE   = 2'd2;

  localparam logic [SEP_LEN_W-1:0] SEP_LEN_RESET = 4'd1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [1:0] CNT_ONE = 2'd1;
  localparam logic [1:0] CNT_TWO = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] start_off;
    logic [POS_W-1:0] end_off;
    logic             present;
    logic             eos;
    logic             err;
  } res_t;

  typedef struct packed {
    res_t       r1;
    res_t       r0;
    logic [1:0] cnt;
  } entry_t;

  function automatic res_t mk_field(input logic [POS_W-1:0] s, input logic [POS_W-1:0] e);
    res_t r;
    r.start_off = s;
    r.end_off   = e;
    r.present   = 1'b1;
    r.eos       = 1'b0;
    r.err       = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_close(input logic err);
    res_t r;
    r.start_off = '0;
    r.end_off   = '0;
    r.present   = 1'b0;
    r.eos       = 1'b0;
    r.err       = err;
    return r;
  endfunction

endpackage

### rtl/core/byte_stream_field_splitter.sv
// Top level of the byte stream field splitter: front end, result queue, back end.
// Depends on bsfs_pkg, bsfs_front, bsfs_queue, bsfs_back.
//
//   channel  dir  handshake             payload
//   in       in   in_valid/in_ready     in_byte, is_last
//   out      out  out_valid/out_ready   field_start, field_end, field_present,
//                                       end_of_string, error_flag
//   cfg      in   cfg_we                cfg_index, cfg_data
//
// One byte per cycle in while the queue has room; one result per cycle out while
// out_ready is high, from the back end's output register. A byte that yields two results
// (separator match on the last byte) occupies the output for both; the QUEUE_DEPTH-entry
// queue absorbs that and output stalls, and input stalls only while the queue is full.
// A result passes through the queue and then the back end's output register before it
// is presented, and waits in the queue while the back end is busy.
// Reset clears string state, queue and output; registers return to their reset values.
module byte_stream_field_splitter import bsfs_pkg::*; #(
  parameter int SEP_MAX     = SEP_MAX_DEF,
  parameter int MAX_LEN     = MAX_LEN_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SEP_BYTES_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   is_last,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [POS_W-1:0]       field_start,
  output logic [POS_W-1:0]       field_end,
  output logic                   field_present,
  output logic                   end_of_string,
  output logic                   error_flag
);

  logic   q_full;
  logic   q_push;
  entry_t q_wdata;
  logic   q_pop;
  logic   q_valid;
  entry_t q_rdata;
  res_t   res;

  bsfs_front #(
    .SEP_MAX(SEP_MAX),
    .MAX_LEN(MAX_LEN)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .is_last  (is_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_wdata)
  );

  bsfs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .rdata(q_rdata)
  );

  bsfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_rdata),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign field_start   = res.start_off;
  assign field_end     = res.end_off;
  assign field_present = res.present;
  assign end_of_string = res.eos;
  assign error_flag    = res.err;

endmodule

### rtl/core/bsfs_front.sv
// Front end: configuration registers, string state and per-byte classification.
// Builds one queue entry of up to two results per byte. Depends on bsfs_pkg.
module bsfs_front import bsfs_pkg::*; #(
  parameter int SEP_MAX = SEP_MAX_DEF,
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [SEP_BYTES_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   is_last,
  input  logic                   q_full,
  output logic                   q_push,
  output entry_t                 q_entry
);

  localparam int HIST_W = (SEP_MAX > 1) ? 8 * (SEP_MAX - 1) : 8;

  logic [SEP_BYTES_W-1:0] sep_bytes;
  logic [SEP_LEN_W-1:0]   sep_len;
  logic                   ws_mode;

  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  fbeg;
  logic [HIST_W-1:0] hist;
  logic              overflow;

  logic [HIST_W+7:0]    win;
  logic [SEP_LEN_W-1:0] len_c;
  logic                 sep_err;
  logic                 ovf_now;
  logic                 active;
  logic [POS_W-1:0]     pos1;
  logic [POS_W-1:0]     span;
  logic                 is_sp;
  logic [SEP_MAX-1:0]   len_hit;
  logic                 match;
  logic [POS_W-1:0]     fbeg_next;
  entry_t               ent;
  logic                 accept;

  assign win      = {hist, in_byte};
  assign len_c    = (sep_len > SEP_LEN_W'(SEP_MAX)) ? SEP_LEN_W'(SEP_MAX) : sep_len;
  assign sep_err  = !ws_mode && (len_c == '0);
  assign ovf_now  = overflow || (pos >= POS_W'(MAX_LEN));
  assign active   = !ovf_now && !sep_err;
  assign pos1     = pos + POS_W'(1);
  assign span     = pos1 - fbeg;
  assign is_sp    = (in_byte == CHAR_SPACE) || (in_byte == CHAR_NL) || (in_byte == CHAR_TAB);
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    for (int l = 1; l <= SEP_MAX; l++) begin
      len_hit[l-1] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (win[8*(l-1-i) +: 8] != sep_bytes[8*i +: 8]) begin
          len_hit[l-1] = 1'b0;
        end
      end
    end
    match = 1'b0;
    for (int l = 1; l <= SEP_MAX; l++) begin
      if (len_c == SEP_LEN_W'(l) && len_hit[l-1]) begin
        match = 1'b1;
      end
    end
    match = match && (pos1 >= fbeg) && (span >= POS_W'(len_c));
  end

  always_comb begin
    ent.r0    = mk_close(1'b0);
    ent.r1    = mk_close(1'b0);
    ent.cnt   = '0;
    fbeg_next = fbeg;
    if (active) begin
      if (ws_mode) begin
        if (is_sp) begin
          if (fbeg < pos) begin
            ent.r0  = mk_field(fbeg, pos);
            ent.cnt = CNT_ONE;
          end
          fbeg_next = pos1;
        end else if (is_last) begin
          ent.r0  = mk_field(fbeg, pos1);
          ent.cnt = CNT_ONE;
        end
      end else begin
        if (match) begin
          ent.r0    = mk_field(fbeg, pos1 - POS_W'(len_c));
          ent.cnt   = CNT_ONE;
          fbeg_next = pos1;
        end
        if (is_last) begin
          if (match) begin
            ent.r1  = mk_field(pos1, pos1);
            ent.cnt = CNT_TWO;
          end else begin
            ent.r0  = mk_field(fbeg, pos1);
            ent.cnt = CNT_ONE;
          end
        end
      end
    end
    if (is_last && (!active || ent.cnt == '0)) begin
      ent.r0  = mk_close(!active);
      ent.cnt = CNT_ONE;
    end
    if (is_last) begin
      if (ent.cnt == CNT_TWO) begin
        ent.r1.eos = 1'b1;
      end else begin
        ent.r0.eos = 1'b1;
      end
    end
  end

  assign q_push  = accept && (ent.cnt != '0);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      sep_bytes <= '0;
      sep_len   <= SEP_LEN_RESET;
      ws_mode   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SEP_BYTES: sep_bytes <= cfg_data;
        REG_SEP_LEN:   sep_len   <= cfg_data[SEP_LEN_W-1:0];
        REG_WS_MODE:   ws_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      fbeg     <= '0;
      hist     <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (is_last) begin
        pos      <= '0;
        fbeg     <= '0;
        hist     <= '0;
        overflow <= 1'b0;
      end else begin
        overflow <= ovf_now;
        if (active) begin
          pos  <= pos1;
          fbeg <= fbeg_next;
          hist <= win[HIST_W-1:0];
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) accept && is_last |=> pos == '0 && !overflow)
    else $error("string state not cleared after last byte");
  assert property (@(posedge clk) disable iff (rst) fbeg <= pos)
    else $error("open field starts past byte position");

endmodule

### rtl/core/bsfs_queue.sv
// Short queue of result entries between front and back ends.
// Register storage, single read port. Depends on bsfs_pkg.
module bsfs_queue import bsfs_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t wdata,
  output logic   full,
  input  logic   pop,
  output logic   valid,
  output entry_t rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign valid   = (count != '0);
  assign rdata   = mem[rptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count past depth");

endmodule

### rtl/core/bsfs_back.sv
// Back end: takes queue entries and sends their results one per cycle while out_ready is high.
// Holds the current entry as the output register. Depends on bsfs_pkg.
module bsfs_back import bsfs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  entry_t q_entry,
  output logic   q_pop,
  output logic   out_valid,
  input  logic   out_ready,
  output res_t   out_res
);

  entry_t cur;
  logic   cur_valid;
  logic   idx;
  logic   last_of_entry;
  logic   out_fire;
  logic   load;

  assign out_valid     = cur_valid;
  assign out_res       = idx ? cur.r1 : cur.r0;
  assign last_of_entry = idx || (cur.cnt == CNT_ONE);
  assign out_fire      = out_valid && out_ready;
  assign load          = !cur_valid || (out_fire && last_of_entry);
  assign q_pop         = load && q_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (load) begin
      cur_valid <= q_valid;
      idx       <= 1'b0;
    end else if (out_fire) begin
      idx <= 1'b1;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
      cur_valid |-> (cur.cnt == CNT_ONE || cur.cnt == CNT_TWO))
    else $error("entry without results in back end");
  assert property (@(posedge clk) disable iff (rst) cur_valid && idx |-> cur.cnt == CNT_TWO)
    else $error("second result selected on single-result entry");
  assert property (@(posedge clk) disable iff (rst)
      out_fire && !idx && cur.cnt == CNT_TWO |=> cur_valid && idx)
    else $error("second result of entry lost");

endmodule

### tb/bsfs_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the byte stream field splitter: tracks string state and registers,
// predicts the results of each accepted byte and checks them in order.
// Depends on bsfs_pkg from the RTL.
package bsfs_tb_pkg;
  import bsfs_pkg::*;

  localparam int SEP_LIMIT = SEP_MAX_DEF;
  localparam int LEN_LIMIT = MAX_LEN_DEF;

  class field_scoreboard;
    logic [SEP_BYTES_W-1:0] sep_bytes;
    logic [SEP_LEN_W-1:0]   sep_len;
    logic                   ws_mode;
    int                     next_pos;
    int                     open_begin;
    logic [55:0]            history;
    bit                     too_long;
    res_t                   awaited[$];
    int                     failures;
    int                     results_seen;
    int                     bytes_seen;
    int                     strings_seen;

    function new();
      sep_bytes    = '0;
      sep_len      = SEP_LEN_RESET;
      ws_mode      = 1'b0;
      failures     = 0;
      results_seen = 0;
      bytes_seen   = 0;
      strings_seen = 0;
      clear_string();
    endfunction

    function void clear_string();
      next_pos   = 0;
      open_begin = 0;
      history    = '0;
      too_long   = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEP_BYTES_W-1:0] data);
      case (idx)
        REG_SEP_BYTES: sep_bytes = data;
        REG_SEP_LEN:   sep_len = data[SEP_LEN_W-1:0];
        REG_WS_MODE:   ws_mode = data[0];
        default: ;
      endcase
    endfunction

    function int active_len();
      return (sep_len > SEP_LIMIT) ? SEP_LIMIT : int'(sep_len);
    endfunction

    function res_t field_result(int s, int e);
      res_t r;
      r.start_off = POS_W'(s);
      r.end_off   = POS_W'(e);
      r.present   = 1'b1;
      r.eos       = 1'b0;
      r.err       = 1'b0;
      return r;
    endfunction

    function res_t close_result(bit err);
      res_t r;
      r.start_off = '0;
      r.end_off   = '0;
      r.present   = 1'b0;
      r.eos       = 1'b0;
      r.err       = err;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic final_byte);
      res_t        fresh[$];
      logic [63:0] win;
      bit          sep_err;
      bit          sep_hit;
      int          len;
      len = active_len();
      sep_err = !ws_mode && len == 0;
      bytes_seen++;
      if (!too_long && next_pos >= LEN_LIMIT) too_long = 1'b1;
      if (!too_long && !sep_err) begin
        win = {history, b};
        if (ws_mode) begin
          if (b == CHAR_SPACE || b == CHAR_NL || b == CHAR_TAB) begin
            if (open_begin < next_pos) fresh.push_back(field_result(open_begin, next_pos));
            open_begin = next_pos + 1;
          end else if (final_byte) begin
            fresh.push_back(field_result(open_begin, next_pos + 1));
          end
        end else begin
          sep_hit = (next_pos + 1 - open_begin >= len);
          for (int i = 0; sep_hit && i < len; i++) begin
            if (win[8*(len-1-i) +: 8] != sep_bytes[8*i +: 8]) sep_hit = 1'b0;
          end
          if (sep_hit) begin
            fresh.push_back(field_result(open_begin, next_pos + 1 - len));
            open_begin = next_pos + 1;
          end
          if (final_byte) fresh.push_back(field_result(open_begin, next_pos + 1));
        end
        history = win[55:0];
        next_pos++;
      end
      if (final_byte) begin
        if (too_long || sep_err || fresh.size() == 0) begin
          fresh.push_back(close_result(too_long || sep_err));
        end
        fresh[fresh.size()-1].eos = 1'b1;
        strings_seen++;
        clear_string();
      end
      foreach (fresh[k]) awaited.push_back(fresh[k]);
    endfunction

    function void compare(string name, logic [POS_W-1:0] want_v, logic [POS_W-1:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        failures++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result: start %0d end %0d present %0b eos %0b err %0b",
               got.start_off, got.end_off, got.present, got.eos, got.err);
        failures++;
        return;
      end
      want = awaited.pop_front();
      results_seen++;
      compare("field_start", want.start_off, got.start_off);
      compare("field_end", want.end_off, got.end_off);
      compare("field_present", POS_W'(want.present), POS_W'(got.present));
      compare("end_of_string", POS_W'(want.eos), POS_W'(got.eos));
      compare("error_flag", POS_W'(want.err), POS_W'(got.err));
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void report_leftovers();
      foreach (awaited[k]) begin
        $error("missing result: start %0d end %0d present %0b eos %0b err %0b",
               awaited[k].start_off, awaited[k].end_off, awaited[k].present,
               awaited[k].eos, awaited[k].err);
      end
      failures += awaited.size();
      awaited.delete();
    endfunction
  endclass

endpackage

### tb/tb_byte_stream_field_splitter.sv
`timescale 1ns / 100ps
// Top of the byte stream field splitter testbench: clock, reset, string stimulus,
// register writes and result collection. Depends on bsfs_pkg and bsfs_tb_pkg.
module tb_byte_stream_field_splitter;
  import bsfs_pkg::*;
  import bsfs_tb_pkg::*;

  localparam int     HOLD_CYCLES   = 400;
  localparam int     SETTLE_CYCLES = 8;
  localparam int     RANDOM_BYTES  = 1400;
  localparam int     DRAIN_LIMIT   = 20000;
  localparam longint LIMIT_NS      = 250_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [SEP_BYTES_W-1:0] cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_byte;
  logic                   is_last;
  logic                   out_valid;
  logic                   out_ready;
  logic [POS_W-1:0]       field_start;
  logic [POS_W-1:0]       field_end;
  logic                   field_present;
  logic                   end_of_string;
  logic                   error_flag;

  field_scoreboard sb;
  logic [7:0]      string_bytes[$];
  bit              tx_steady;
  bit              rx_steady;
  bit              hold_req;
  int              reg_writes;

  byte_stream_field_splitter u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .field_start   (field_start),
    .field_end     (field_end),
    .field_present (field_present),
    .end_of_string (end_of_string),
    .error_flag    (error_flag)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap(bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 95) return $urandom_range(9, 24);
    return $urandom_range(25, 60);
  endfunction

  // receive results; hold off output on request
  initial begin
    int   stall_left;
    res_t got;
    out_ready <= 1'b0;
    stall_left = 0;
    do @(posedge clk); while (rst);
    forever begin
      if (out_valid && out_ready) begin
        got.start_off = field_start;
        got.end_off   = field_end;
        got.present   = field_present;
        got.eos       = end_of_string;
        got.err       = error_flag;
        sb.check_result(got);
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall_left == 0 && $urandom_range(0, 99) < 25) stall_left = pick_gap(rx_steady);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic final_byte);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    is_last  <= final_byte;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(b, final_byte);
  endtask

  task automatic send_string();
    foreach (string_bytes[k]) send_byte(string_bytes[k], k == string_bytes.size() - 1);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SEP_BYTES_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    reg_writes++;
  endtask

  task automatic fill_string(input int n);
    int eff;
    int r;
    int idx;
    string_bytes.delete();
    eff = sb.active_len();
    while (string_bytes.size() < n) begin
      r = $urandom_range(0, 99);
      if (r < 20 && eff > 0) begin
        for (int k = 0; k < eff; k++) string_bytes.push_back(sb.sep_bytes[8*k +: 8]);
      end else if (r < 40) begin
        idx = $urandom_range(0, 7);
        string_bytes.push_back(sb.sep_bytes[8*idx +: 8]);
      end else if (r < 55) begin
        case ($urandom_range(0, 2))
          0:       string_bytes.push_back(CHAR_SPACE);
          1:       string_bytes.push_back(CHAR_NL);
          default: string_bytes.push_back(CHAR_TAB);
        endcase
      end else begin
        string_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    while (string_bytes.size() > n) void'(string_bytes.pop_back());
  endtask

  task automatic random_settings();
    int          r;
    logic [63:0] pattern;
    if ($urandom_range(0, 3) != 0) begin
      pattern = {$urandom, $urandom};
      pattern[0] = ($urandom_range(0, 99) < 35);
      write_reg(REG_WS_MODE, pattern);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 99);
      pattern = {$urandom, $urandom};
      if (r < 6) pattern[SEP_LEN_W-1:0] = '0;
      else if (r < 14) pattern[SEP_LEN_W-1:0] = SEP_LEN_W'($urandom_range(SEP_LIMIT + 1, 15));
      else pattern[SEP_LEN_W-1:0] = SEP_LEN_W'($urandom_range(1, SEP_LIMIT));
      write_reg(REG_SEP_LEN, pattern);
    end
    if ($urandom_range(0, 3) != 0) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        pattern = {8{8'($urandom_range(0, 255))}};
      end else if (r < 35) begin
        for (int k = 0; k < 8; k++) pattern[8*k +: 8] = $urandom_range(0, 1) ? 8'h61 : 8'h62;
      end else if (r < 40) begin
        pattern = $urandom_range(0, 1) ? '1 : '0;
      end else begin
        pattern = {$urandom, $urandom};
      end
      write_reg(REG_SEP_BYTES, pattern);
    end
    if ($urandom_range(0, 19) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    tx_steady = ($urandom_range(0, 4) == 0);
    rx_steady = ($urandom_range(0, 4) == 0);
  endtask

  initial begin
    int random_sent;
    int waited;
    sb = new();
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= REG_SEP_BYTES;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_byte   <= '0;
    is_last   <= 1'b0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    hold_req = 1'b0;
    reg_writes = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: one-byte separator 0x00
    string_bytes = '{8'h00};
    send_string();
    string_bytes = '{8'h41};
    send_string();
    string_bytes = '{8'hFF, 8'h00, 8'h00};
    send_string();
    settle();

    write_reg(REG_WS_MODE, '1);
    string_bytes = '{CHAR_SPACE};
    send_string();
    string_bytes = '{CHAR_TAB, 8'h61, CHAR_SPACE, CHAR_SPACE, 8'h62, CHAR_NL};
    send_string();
    settle();

    write_reg(REG_WS_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(REG_SEP_LEN, 64'hFFFF_FFFF_FFFF_FFF0);
    string_bytes = '{8'h78, 8'h79};
    send_string();
    settle();

    write_reg(REG_SEP_BYTES, '1);
    write_reg(REG_SEP_LEN, 64'hF);
    write_reg(REG_UNUSED, {$urandom, $urandom});
    string_bytes.delete();
    repeat (8) string_bytes.push_back(8'hFF);
    send_string();
    settle();

    // hold the output while input keeps coming
    write_reg(REG_SEP_BYTES, 64'h61);
    write_reg(REG_SEP_LEN, 64'h1);
    tx_steady = 1'b1;
    hold_req = 1'b1;
    repeat (3) begin
      fill_string(40);
      send_string();
    end
    settle();
    tx_steady = 1'b0;

    random_sent = 0;
    while (random_sent < RANDOM_BYTES) begin
      random_settings();
      repeat ($urandom_range(3, 8)) begin
        fill_string(pick_length());
        send_string();
        random_sent += string_bytes.size();
      end
      settle();
    end

    waited = 0;
    while (sb.pending() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    sb.report_leftovers();
    $display("Checked %0d results from %0d bytes in %0d strings, %0d register writes.",
             sb.results_seen, sb.bytes_seen, sb.strings_seen, reg_writes);
    $display("Covered separator, whitespace and error cases and a %0d-cycle output hold.",
             HOLD_CYCLES);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
